[sv/sdtq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted deadline timer queue.
// No dependencies; used by sdtq_cell and sorted_deadline_timer_queue_top.
package sdtq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = 5;   // holds 0..QUEUE_DEPTH
  localparam int unsigned DL_W        = 64;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned FREQ_W      = 32;
  localparam int unsigned DELAY_W     = 32;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd19200000;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } sdtq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SHIFT,
    S_LOAD,
    S_OUT
  } sdtq_state_e;

  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [TAG_W-1:0] tag;
  } sdtq_entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [DL_W-1:0]  dl;
    logic [TAG_W-1:0] tag;
  } sdtq_ctrl_t;

endpackage

[sv/sdtq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a deadline and tag, compares against
// the broadcast deadline and shifts with its neighbors. Uses sdtq_pkg.
module sdtq_cell (
  input  logic                clk_i,
  input  sdtq_pkg::sdtq_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  sdtq_pkg::sdtq_entry_t left_i,
  input  logic                left_stay_i,
  input  sdtq_pkg::sdtq_entry_t right_i,
  output sdtq_pkg::sdtq_entry_t entry_o,
  output logic                stay_o
);

  sdtq_pkg::sdtq_entry_t entry_q, entry_d;

  // Stays put when it holds an entry due no later than the new one
  assign stay_o  = occ_i && (entry_q.dl <= ctrl_i.dl);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!stay_o) begin
        if (left_stay_i) begin
          entry_d.dl  = ctrl_i.dl;
          entry_d.tag = ctrl_i.tag;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[sv/sorted_deadline_timer_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the sorted deadline timer queue: sequencer, deadline math
// and the cell chain. Depends on sdtq_pkg and sdtq_cell.
//
// Usage:
//  - Request channel: in_valid_i / in_stall_o with cmd_i, now_count_i,
//    delay_seconds_i, event_tag_i. cmd_i insert adds an event due at
//    now + delay * tick_frequency (mod 2^64); cmd_i expire pops the head.
//  - Result channel: out_valid_o / out_stall_i, one result per request,
//    carrying the popped tag, timer enable/load, entry count and status.
//  - cfg_we_i writes cfg_wdata_i into tick_frequency; write only when idle.
//  - One request is worked at a time. An insert goes through multiply,
//    add, one chain shift and load subtract before out_valid_o; an
//    expiry skips the multiply and add, and a rejected request goes
//    straight to the load subtract. The next request is taken the cycle
//    after the result is accepted.
//  - All 16 cells of the chain shift together; the multiply and the
//    64-bit add/subtract each own a state.
//  - Reset empties the queue, disables the timer and restores
//    tick_frequency to 19200000. A stalled result holds until taken.
module sorted_deadline_timer_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sdtq_pkg::FREQ_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [sdtq_pkg::DL_W-1:0]         now_count_i,
  input  logic [sdtq_pkg::DELAY_W-1:0]      delay_seconds_i,
  input  logic [sdtq_pkg::TAG_W-1:0]        event_tag_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              expired_valid_o,
  output logic [sdtq_pkg::TAG_W-1:0]        expired_tag_o,
  output logic                              timer_enable_o,
  output logic signed [sdtq_pkg::DL_W-1:0]  timer_load_o,
  output logic [sdtq_pkg::CNT_W-1:0]        queue_count_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned N = sdtq_pkg::QUEUE_DEPTH;

  sdtq_pkg::sdtq_state_e state_q, state_d;
  sdtq_pkg::sdtq_status_e status_q;
  sdtq_pkg::sdtq_ctrl_t  ctrl;

  logic [sdtq_pkg::FREQ_W-1:0]  freq_q;
  logic [sdtq_pkg::CNT_W-1:0]   count_q;
  logic                         cmd_q;
  logic [sdtq_pkg::DL_W-1:0]    now_q;
  logic [sdtq_pkg::DELAY_W-1:0] delay_q;
  logic [sdtq_pkg::TAG_W-1:0]   tag_q;
  logic [sdtq_pkg::DL_W-1:0]    prod_q;
  logic [sdtq_pkg::DL_W-1:0]    dl_q;
  logic                         exp_valid_q;
  logic [sdtq_pkg::TAG_W-1:0]   exp_tag_q;
  logic [sdtq_pkg::DL_W-1:0]    load_q;

  logic in_acc;
  logic full;
  logic empty;

  sdtq_pkg::sdtq_entry_t cell_entry [N];
  logic                  cell_stay  [N];

  assign in_acc = in_valid_i && !in_stall_o;
  assign full   = (count_q == sdtq_pkg::CNT_W'(N));
  assign empty  = (count_q == '0);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    ctrl.ins = 1'b0;
    ctrl.pop = 1'b0;
    ctrl.dl  = dl_q;
    ctrl.tag = tag_q;
    case (state_q)
      sdtq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == sdtq_pkg::CMD_INSERT && !full) begin
            state_d = sdtq_pkg::S_MUL;
          end else if (cmd_i == sdtq_pkg::CMD_EXPIRE && !empty) begin
            state_d = sdtq_pkg::S_SHIFT;
          end else begin
            state_d = sdtq_pkg::S_LOAD;
          end
        end
      end
      sdtq_pkg::S_MUL:   state_d = sdtq_pkg::S_ADD;
      sdtq_pkg::S_ADD:   state_d = sdtq_pkg::S_SHIFT;
      sdtq_pkg::S_SHIFT: begin
        ctrl.ins = (cmd_q == sdtq_pkg::CMD_INSERT);
        ctrl.pop = (cmd_q == sdtq_pkg::CMD_EXPIRE);
        state_d  = sdtq_pkg::S_LOAD;
      end
      sdtq_pkg::S_LOAD:  state_d = sdtq_pkg::S_OUT;
      sdtq_pkg::S_OUT: begin
        if (!out_stall_i) begin
          state_d = sdtq_pkg::S_IDLE;
        end
      end
      default: state_d = sdtq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdtq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= sdtq_pkg::FREQ_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
      if (ctrl.ins) begin
        count_q <= count_q + sdtq_pkg::CNT_W'(1);
      end else if (ctrl.pop) begin
        count_q <= count_q - sdtq_pkg::CNT_W'(1);
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q       <= cmd_i;
      now_q       <= now_count_i;
      delay_q     <= delay_seconds_i;
      tag_q       <= event_tag_i;
      exp_valid_q <= 1'b0;
      exp_tag_q   <= '0;
      if (cmd_i == sdtq_pkg::CMD_INSERT && full) begin
        status_q <= sdtq_pkg::STAT_FULL;
      end else if (cmd_i == sdtq_pkg::CMD_EXPIRE && empty) begin
        status_q <= sdtq_pkg::STAT_EMPTY;
      end else begin
        status_q <= sdtq_pkg::STAT_OK;
      end
    end
    if (state_q == sdtq_pkg::S_MUL) begin
      prod_q <= sdtq_pkg::DL_W'(delay_q) * sdtq_pkg::DL_W'(freq_q);
    end
    if (state_q == sdtq_pkg::S_ADD) begin
      dl_q <= now_q + prod_q;
    end
    if (ctrl.pop) begin
      exp_valid_q <= 1'b1;
      exp_tag_q   <= cell_entry[0].tag;
    end
    if (state_q == sdtq_pkg::S_LOAD) begin
      load_q <= empty ? '0 : (cell_entry[0].dl - now_q);
    end
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < N; i++) begin : g_cell
    sdtq_pkg::sdtq_entry_t left, right;
    logic                  left_stay;
    logic                  occ;

    assign occ = (sdtq_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left      = cell_entry[i-1];
      assign left_stay = cell_stay[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_entry[i+1];
    end

    sdtq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_i      (left),
      .left_stay_i (left_stay),
      .right_i     (right),
      .entry_o     (cell_entry[i]),
      .stay_o      (cell_stay[i])
    );
  end

  // ---------------- outputs ----------------
  assign in_stall_o      = (state_q != sdtq_pkg::S_IDLE);
  assign out_valid_o     = (state_q == sdtq_pkg::S_OUT);
  assign expired_valid_o = exp_valid_q;
  assign expired_tag_o   = exp_tag_q;
  assign timer_enable_o  = !empty;
  assign timer_load_o    = load_q;
  assign queue_count_o   = count_q;
  assign status_o        = status_q;

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sdtq_pkg::CNT_W'(N))
    else $error("entry count above queue depth");

  a_shift_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sdtq_pkg::S_SHIFT |=> count_q != $past(count_q))
    else $error("chain shift did not change entry count");

  a_pop_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_valid_o |-> status_o == sdtq_pkg::STAT_OK)
    else $error("popped entry reported with error status");

  a_reject_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((cmd_i == sdtq_pkg::CMD_INSERT && full) ||
               (cmd_i == sdtq_pkg::CMD_EXPIRE && empty))
    |=> state_q == sdtq_pkg::S_LOAD && $stable(count_q))
    else $error("rejected request changed the queue");

endmodule
